FILE: rtl/core/bdc_pkg.sv
package bdc_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int BTN_W       = 3;

    localparam logic [7:0]  COUNT8_LIMIT  = 8'hFF;
    localparam logic [15:0] COUNT16_LIMIT = 16'hFFFF;

    localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [1:0] CFG_CLICK      = 2'd2;
    localparam logic [1:0] CFG_HOLD       = 2'd3;

    localparam logic [7:0]  DEBOUNCE_RST   = 8'd3;
    localparam logic [15:0] LONG_PRESS_RST = 16'd100;
    localparam logic [15:0] CLICK_RST      = 16'd30;
    localparam logic [15:0] HOLD_RST       = 16'd20;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_RELEASED = 2'd2,
        PH_HELD     = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_LONG    = 3'd3,
        EV_CLICK   = 3'd4,
        EV_HOLD    = 3'd5
    } t_event;

    typedef struct packed {
        logic        stable;
        logic [7:0]  db_cnt;
        t_phase      phase;
        logic [15:0] ticks;
        logic [7:0]  presses;
        t_event      last_ev;
    } t_btn_state;

    typedef struct packed {
        logic [7:0]  debounce;
        logic [15:0] long_press;
        logic [15:0] click;
        logic [15:0] hold;
    } t_cfg;

    typedef struct packed {
        t_event     ev;
        logic       raised;
        logic [7:0] count;
    } t_result;

endpackage

FILE: rtl/core/bdc_in_if.sv
interface bdc_in_if;
    import bdc_pkg::*;

    logic             valid;
    logic             ready;
    logic [BTN_W-1:0] button_index;
    logic             raw_level;

    modport source (output valid, output button_index, output raw_level, input ready);
    modport sink (input valid, input button_index, input raw_level, output ready);
endinterface

FILE: rtl/core/bdc_out_if.sv
interface bdc_out_if;
    import bdc_pkg::*;

    logic             valid;
    logic             ready;
    logic [BTN_W-1:0] out_index;
    logic [2:0]       latched_event;
    logic             event_raised;
    logic [7:0]       click_count;

    modport source (
        output valid, output out_index, output latched_event,
        output event_raised, output click_count, input ready
    );
    modport sink (
        input valid, input out_index, input latched_event,
        input event_raised, input click_count, output ready
    );
endinterface

FILE: rtl/core/button_debounce_click_long_press_fsm.sv
// stages: stage 1 registers a request with its state memory read, and the output
//   register holds its result while o_res.ready is low; one request per cycle when
//   not stalled, separate read/write ports, forwarding between back-to-back requests
// reset: synchronous, active low; clears the per-button valid bits at once, so every
//   button reads as released and idle, and restores the register defaults
module button_debounce_click_long_press_fsm
    import bdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdc_in_if.sink      i_req,
    bdc_out_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg             r_cfg;

    logic             r_s1_valid;
    logic [BTN_W-1:0] r_s1_idx;
    logic             r_s1_raw;
    logic             r_s1_in_range;
    logic             r_fwd_hit;
    t_btn_state       r_fwd_state;

    logic             r_o_valid;
    logic [BTN_W-1:0] r_o_idx;
    t_result          r_o_res;

    logic             out_free;
    logic             s1_adv;
    logic             in_ready;
    logic             in_acc;
    logic             in_range;
    logic             wr_en;
    t_btn_state       mem_rd;
    t_btn_state       cur_state;
    t_btn_state       n_state;
    t_result          step_res;

    assign out_free  = !r_o_valid || o_res.ready;
    assign s1_adv    = r_s1_valid && out_free;
    assign in_ready  = !r_s1_valid || out_free;
    assign in_acc    = i_req.valid && in_ready;
    assign in_range  = {1'b0, i_req.button_index} < (BTN_W + 1)'(NUM_BUTTONS);
    assign wr_en     = s1_adv && r_s1_in_range;
    assign cur_state = r_fwd_hit ? r_fwd_state : mem_rd;

    assign i_req.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce   <= DEBOUNCE_RST;
            r_cfg.long_press <= LONG_PRESS_RST;
            r_cfg.click      <= CLICK_RST;
            r_cfg.hold       <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:   r_cfg.debounce   <= i_cfg_data[7:0];
                CFG_LONG_PRESS: r_cfg.long_press <= i_cfg_data;
                CFG_CLICK:      r_cfg.click      <= i_cfg_data;
                CFG_HOLD:       r_cfg.hold       <= i_cfg_data;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    bdc_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_req.button_index),
        .o_rd_data (mem_rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (n_state)
    );

    bdc_phase_logic u_phase (
        .i_state  (cur_state),
        .i_raw    (r_s1_raw),
        .i_cfg    (r_cfg),
        .o_next   (n_state),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            // previous request writes the same entry at this edge
            r_fwd_hit  <= wr_en && (r_s1_idx == i_req.button_index);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_idx      <= i_req.button_index;
            r_s1_raw      <= i_req.raw_level;
            r_s1_in_range <= in_range;
            r_fwd_state   <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_idx <= r_s1_idx;
            r_o_res <= r_s1_in_range ? step_res : '0;
        end
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.out_index     = r_o_idx;
    assign o_res.latched_event = r_o_res.ev;
    assign o_res.event_raised  = r_o_res.raised;
    assign o_res.click_count   = r_o_res.count;

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

    a_raised_has_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.event_raised |-> o_res.latched_event != EV_NONE)
        else $error("raised flag without event");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.event_raised
        && (o_res.latched_event == EV_LONG || o_res.latched_event == EV_CLICK)
        |-> o_res.click_count == 8'd0)
        else $error("click count not cleared on long press or click");

    a_stall_blocks_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |-> !in_acc)
        else $error("request accepted over stalled stage");

    a_fwd_only_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !wr_en |=> !r_fwd_hit)
        else $error("forward hit without a write");

endmodule

FILE: rtl/core/bdc_state_mem.sv
module bdc_state_mem
    import bdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [BTN_W-1:0] i_rd_addr,
    output t_btn_state       o_rd_data,
    input  logic             i_wr_en,
    input  logic [BTN_W-1:0] i_wr_addr,
    input  t_btn_state       i_wr_data
);

    t_btn_state             r_mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_valid;
    t_btn_state             r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // entries not yet written read as the cleared state
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/bdc_phase_logic.sv
module bdc_phase_logic
    import bdc_pkg::*;
(
    input  t_btn_state i_state,
    input  logic       i_raw,
    input  t_cfg       i_cfg,
    output t_btn_state o_next,
    output t_result    o_result
);

    t_btn_state n_st;
    logic [7:0] db_inc;
    logic [7:0] press_inc;
    logic       raised;

    always_comb begin
        n_st      = i_state;
        raised    = 1'b0;
        db_inc    = (i_state.db_cnt != COUNT8_LIMIT) ? i_state.db_cnt + 8'd1
                                                     : i_state.db_cnt;
        press_inc = (i_state.presses != COUNT8_LIMIT) ? i_state.presses + 8'd1
                                                      : i_state.presses;

        // debounce
        if (i_raw != i_state.stable) begin
            n_st.db_cnt = db_inc;
            if (db_inc >= i_cfg.debounce) begin
                n_st.stable = i_raw;
                n_st.db_cnt = '0;
            end
        end else begin
            n_st.db_cnt = '0;
        end

        if (i_state.phase != PH_IDLE && i_state.ticks != COUNT16_LIMIT) begin
            n_st.ticks = i_state.ticks + 16'd1;
        end

        case (i_state.phase)
            PH_IDLE: begin
                if (n_st.stable) begin
                    n_st.last_ev = EV_PRESS;
                    raised       = 1'b1;
                    n_st.presses = press_inc;
                    n_st.ticks   = '0;
                    n_st.phase   = PH_PRESSED;
                end else begin
                    n_st.last_ev = EV_NONE;
                end
            end
            PH_PRESSED: begin
                if (!n_st.stable) begin
                    n_st.last_ev = EV_RELEASE;
                    raised       = 1'b1;
                    n_st.ticks   = '0;
                    n_st.phase   = PH_RELEASED;
                end else if (n_st.ticks >= i_cfg.long_press) begin
                    n_st.last_ev = EV_LONG;
                    raised       = 1'b1;
                    n_st.presses = '0;
                    n_st.ticks   = '0;
                    n_st.phase   = PH_HELD;
                end
            end
            PH_RELEASED: begin
                if (n_st.stable) begin
                    n_st.last_ev = EV_PRESS;
                    raised       = 1'b1;
                    n_st.presses = press_inc;
                    n_st.ticks   = '0;
                    n_st.phase   = PH_PRESSED;
                end else if (n_st.ticks >= i_cfg.click) begin
                    n_st.last_ev = EV_CLICK;
                    raised       = 1'b1;
                    n_st.presses = '0;
                    n_st.ticks   = '0;
                    n_st.phase   = PH_IDLE;
                end
            end
            PH_HELD: begin
                if (!n_st.stable) begin
                    n_st.last_ev = EV_RELEASE;
                    raised       = 1'b1;
                    n_st.presses = '0;
                    n_st.ticks   = '0;
                    n_st.phase   = PH_IDLE;
                end else if (n_st.ticks >= i_cfg.hold) begin
                    n_st.last_ev = EV_HOLD;
                    raised       = 1'b1;
                    n_st.ticks   = '0;
                end
            end
            default: begin
                n_st = i_state;
            end
        endcase
    end

    assign o_next          = n_st;
    assign o_result.ev     = n_st.last_ev;
    assign o_result.raised = raised;
    assign o_result.count  = n_st.presses;

endmodule
